// ===== sv/lpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and helpers for the projection region unit
// Register indexes, status codes, reset values, and the clamp and
// empty-range repair used for both detector axes.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Width of a floored or ceiled detector index before it is clamped.
  localparam int IDX_W = 25;

  typedef enum logic [2:0] {
    REG_VOL_X_START = 3'd0,
    REG_VOL_X_END   = 3'd1,
    REG_VOL_Y_START = 3'd2,
    REG_VOL_Y_END   = 3'd3,
    REG_Z_LOW       = 3'd4,
    REG_Z_HIGH      = 3'd5,
    REG_PROJ_WIDTH  = 3'd6,
    REG_PROJ_HEIGHT = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_EXTEND = 2'd1,
    ST_INVERTED  = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] first_idx;
    logic [15:0] end_idx;
    status_t     status;
  } range_t;

  localparam logic signed [15:0] RST_VOL_X_START = 16'sd0;
  localparam logic signed [15:0] RST_VOL_X_END   = 16'sd256;
  localparam logic signed [15:0] RST_VOL_Y_START = 16'sd0;
  localparam logic signed [15:0] RST_VOL_Y_END   = 16'sd256;
  localparam logic signed [23:0] RST_Z_LOW       = 24'sd0;
  localparam logic signed [23:0] RST_Z_HIGH      = 24'sd0;
  localparam logic [15:0]        RST_PROJ_WIDTH  = 16'd2048;
  localparam logic [15:0]        RST_PROJ_HEIGHT = 16'd2048;

  // Clamp a signed index to [0, size].
  function automatic logic [15:0] clamp_idx(input logic signed [IDX_W-1:0] v,
                                            input logic [15:0] size);
    logic signed [IDX_W-1:0] sz;
    sz = IDX_W'(signed'({1'b0, size}));
    if (v[IDX_W-1]) begin
      return 16'd0;
    end else if (v > sz) begin
      return size;
    end else begin
      return v[15:0];
    end
  endfunction

  // Grow an empty range by one pixel, upward when there is room, and flag
  // ranges that cannot be grown or that are inverted.
  function automatic range_t fix_range(input logic [15:0] f, input logic [15:0] e,
                                       input logic [15:0] size);
    range_t r;
    r.first_idx = f;
    r.end_idx   = e;
    r.status    = ST_OK;
    if (f == e) begin
      if (e < size) begin
        r.end_idx = e + 16'd1;
      end else if (f != 16'd0) begin
        r.first_idx = f - 16'd1;
      end else begin
        r.status = ST_NO_EXTEND;
      end
    end else if (f > e) begin
      r.status = ST_INVERTED;
    end
    return r;
  endfunction

endpackage

// ===== sv/lamino_projection_roi_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamino_projection_roi_unit: detector region touched by a volume region
// Projects the corners of a laminographic volume region for one angle and
// returns the clamped column and row ranges of the projection it touches.
// ----------------------------------------------------------------------------
// Usage:
// One input transaction carries the precomputed sine and cosine of the
// tomographic and laminographic angles (Q1.14) and the rotation center
// (Q8). For each input transaction exactly one output transaction follows,
// in order, with the column range, the row range and a status per axis.
// The volume bounds and the projection size are set through the write port
// (cfg_write, cfg_index, cfg_data) while no transaction is in flight.
//
// out_valid rises once a transaction has been registered through stages 1
// to 6. The block is a six-stage pipeline and takes one transaction in every
// cycle unless in_stall holds it; the depth is set by the corner products,
// the 34x16 row multiply, the wide row sum and the floor/clamp and repair
// steps.
//
// Each stage holds a valid bit and advances when it is empty or when the
// stage after it advances, so bubbles close up. When the receiver asserts
// out_stall, the output register holds its transaction and the stages
// behind it keep filling; in_stall rises only once every stage is full.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module lamino_projection_roi_unit (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [23:0]           cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    tomo_sine,
  input  logic signed [15:0]    tomo_cosine,
  input  logic signed [15:0]    lamino_sine,
  input  logic signed [15:0]    lamino_cosine,
  input  logic signed [23:0]    center_x,
  input  logic signed [23:0]    center_y,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           col_first,
  output logic [15:0]           col_end,
  output logic [15:0]           row_first,
  output logic [15:0]           row_end,
  output lpr_pkg::status_t      col_status,
  output lpr_pkg::status_t      row_status
);
  import lpr_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] vol_x_start;
  logic signed [15:0] vol_x_end;
  logic signed [15:0] vol_y_start;
  logic signed [15:0] vol_y_end;
  logic signed [23:0] z_low;
  logic signed [23:0] z_high;
  logic [15:0]        proj_width;
  logic [15:0]        proj_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_x_start <= RST_VOL_X_START;
      vol_x_end   <= RST_VOL_X_END;
      vol_y_start <= RST_VOL_Y_START;
      vol_y_end   <= RST_VOL_Y_END;
      z_low       <= RST_Z_LOW;
      z_high      <= RST_Z_HIGH;
      proj_width  <= RST_PROJ_WIDTH;
      proj_height <= RST_PROJ_HEIGHT;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_VOL_X_START: vol_x_start <= cfg_data[15:0];
        REG_VOL_X_END:   vol_x_end   <= cfg_data[15:0];
        REG_VOL_Y_START: vol_y_start <= cfg_data[15:0];
        REG_VOL_Y_END:   vol_y_end   <= cfg_data[15:0];
        REG_Z_LOW:       z_low       <= cfg_data;
        REG_Z_HIGH:      z_high      <= cfg_data;
        REG_PROJ_WIDTH:  proj_width  <= cfg_data[15:0];
        REG_PROJ_HEIGHT: proj_height <= cfg_data[15:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Stage k loads when it is empty or stage k+1 loads.
  // Stage 6 is the output register.
  // --------------------------------------------------------------------------
  logic [6:1] vld;
  logic [6:1] en;

  always_comb begin
    en[6] = !vld[6] || !out_stall;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: corner selection by the angle signs and all corner products.
  // The inclusive upper bounds are the right-open ends minus one.
  // --------------------------------------------------------------------------
  logic signed [16:0] x0, x1, y0, y1;
  logic signed [16:0] cxs, cxe, cys, cye;   // column corners
  logic signed [16:0] rxs, rxe, rys, rye;   // row corners

  always_comb begin
    x0 = 17'(vol_x_start);
    x1 = 17'(vol_x_end) - 17'sd1;
    y0 = 17'(vol_y_start);
    y1 = 17'(vol_y_end) - 17'sd1;
    // Columns: a negative sine swaps the y corners, a negative cosine the x.
    cxs = tomo_cosine[15] ? x1 : x0;
    cxe = tomo_cosine[15] ? x0 : x1;
    cys = tomo_sine[15] ? y1 : y0;
    cye = tomo_sine[15] ? y0 : y1;
    // Rows: a negative sine swaps the x corners, a positive cosine the y.
    rxs = tomo_sine[15] ? x1 : x0;
    rxe = tomo_sine[15] ? x0 : x1;
    rys = (!tomo_cosine[15] && tomo_cosine != 16'sd0) ? y1 : y0;
    rye = (!tomo_cosine[15] && tomo_cosine != 16'sd0) ? y0 : y1;
  end

  logic signed [32:0] s1_c_xlo, s1_c_xhi, s1_s_ylo, s1_s_yhi;
  logic signed [32:0] s1_s_xlo, s1_s_xhi, s1_c_ylo, s1_c_yhi;
  logic signed [39:0] s1_zl_ls, s1_zh_ls;
  logic signed [23:0] s1_cx, s1_cy;
  logic signed [15:0] s1_lc;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_c_xlo <= 33'(tomo_cosine) * 33'(cxs);
      s1_c_xhi <= 33'(tomo_cosine) * 33'(cxe);
      s1_s_ylo <= 33'(tomo_sine) * 33'(cys);
      s1_s_yhi <= 33'(tomo_sine) * 33'(cye);
      s1_s_xlo <= 33'(tomo_sine) * 33'(rxs);
      s1_s_xhi <= 33'(tomo_sine) * 33'(rxe);
      s1_c_ylo <= 33'(tomo_cosine) * 33'(rys);
      s1_c_yhi <= 33'(tomo_cosine) * 33'(rye);
      s1_zl_ls <= 40'(z_low) * 40'(lamino_sine);
      s1_zh_ls <= 40'(z_high) * 40'(lamino_sine);
      s1_cx    <= center_x;
      s1_cy    <= center_y;
      s1_lc    <= lamino_cosine;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: column bounds in Q14, widened by one pixel; row in-plane terms.
  // --------------------------------------------------------------------------
  logic signed [34:0] s2_col_lo, s2_col_hi;
  logic signed [33:0] s2_row_tlo, s2_row_thi;
  logic signed [39:0] s2_zl_ls, s2_zh_ls;
  logic signed [23:0] s2_cy;
  logic signed [15:0] s2_lc;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_col_lo  <= 35'(s1_c_xlo) + 35'(s1_s_ylo) + (35'(s1_cx) <<< 6) - 35'sd16384;
      s2_col_hi  <= 35'(s1_c_xhi) + 35'(s1_s_yhi) + (35'(s1_cx) <<< 6) + 35'sd16384;
      s2_row_tlo <= 34'(s1_s_xlo) - 34'(s1_c_ylo);
      s2_row_thi <= 34'(s1_s_xhi) - 34'(s1_c_yhi);
      s2_zl_ls   <= s1_zl_ls;
      s2_zh_ls   <= s1_zh_ls;
      s2_cy      <= s1_cy;
      s2_lc      <= s1_lc;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: column floor/ceil and clamp; row in-plane terms times the
  // laminographic cosine.
  // --------------------------------------------------------------------------
  logic signed [IDX_W-1:0] col_fl, col_cl;

  always_comb begin
    col_fl = IDX_W'(s2_col_lo >>> 14);
    col_cl = IDX_W'((36'(s2_col_hi) + 36'sd16383) >>> 14);
  end

  logic [15:0]        s3_col_f, s3_col_e;
  logic signed [49:0] s3_row_plo, s3_row_phi;
  logic signed [39:0] s3_zl_ls, s3_zh_ls;
  logic signed [23:0] s3_cy;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_col_f   <= clamp_idx(col_fl, proj_width);
      s3_col_e   <= clamp_idx(col_cl, proj_width);
      s3_row_plo <= 50'(s2_row_tlo) * 50'(s2_lc);
      s3_row_phi <= 50'(s2_row_thi) * 50'(s2_lc);
      s3_zl_ls   <= s2_zl_ls;
      s3_zh_ls   <= s2_zh_ls;
      s3_cy      <= s2_cy;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: column range repair; row bounds in Q28, widened by one pixel.
  // --------------------------------------------------------------------------
  range_t             s4_col;
  logic signed [51:0] s4_row_lo, s4_row_hi;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_col    <= fix_range(s3_col_f, s3_col_e, proj_width);
      s4_row_lo <= 52'(s3_row_plo) + (52'(s3_zl_ls) <<< 6) + (52'(s3_cy) <<< 20)
                   - 52'sd268435456;
      s4_row_hi <= 52'(s3_row_phi) + (52'(s3_zh_ls) <<< 6) + (52'(s3_cy) <<< 20)
                   + 52'sd268435456;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: row floor/ceil and clamp.
  // --------------------------------------------------------------------------
  logic signed [IDX_W-1:0] row_fl, row_cl;

  always_comb begin
    row_fl = IDX_W'(s4_row_lo >>> 28);
    row_cl = IDX_W'((53'(s4_row_hi) + 53'sd268435455) >>> 28);
  end

  range_t      s5_col;
  logic [15:0] s5_row_f, s5_row_e;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_col   <= s4_col;
      s5_row_f <= clamp_idx(row_fl, proj_height);
      s5_row_e <= clamp_idx(row_cl, proj_height);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: row range repair into the output register.
  // --------------------------------------------------------------------------
  range_t row_fix;

  assign row_fix = fix_range(s5_row_f, s5_row_e, proj_height);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      col_first  <= s5_col.first_idx;
      col_end    <= s5_col.end_idx;
      col_status <= s5_col.status;
      row_first  <= row_fix.first_idx;
      row_end    <= row_fix.end_idx;
      row_status <= row_fix.status;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_flush_on_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (col_status != ST_OK || col_first < col_end) &&
                  (row_status != ST_OK || row_first < row_end))
    else $error("range reported ok but empty or inverted");

  a_inverted_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (col_status != ST_INVERTED || col_first > col_end) &&
                  (row_status != ST_INVERTED || row_first > row_end))
    else $error("range reported inverted but is not");

  a_no_extend_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (col_status != ST_NO_EXTEND || col_first == col_end) &&
                  (row_status != ST_NO_EXTEND || row_first == row_end))
    else $error("range reported as not extendable but is not empty");

endmodule

// ===== sim/lamino_projection_roi_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamino_projection_roi_unit_test: self-checking bench for the region unit
// Drives angle transactions through the valid/stall handshake with random
// gaps and back-pressure. A scoreboard recomputes every column and row range
// in 64-bit fixed point and checks each output transaction in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [15:0] tomo_sine;
  logic signed [15:0] tomo_cosine;
  logic signed [15:0] lamino_sine;
  logic signed [15:0] lamino_cosine;
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
} angle_t;

typedef struct packed {
  logic [15:0]      col_first;
  logic [15:0]      col_end;
  logic [15:0]      row_first;
  logic [15:0]      row_end;
  lpr_pkg::status_t col_status;
  lpr_pkg::status_t row_status;
} region_t;

typedef struct {
  logic signed [15:0] x_start;
  logic signed [15:0] x_end;
  logic signed [15:0] y_start;
  logic signed [15:0] y_end;
  logic signed [23:0] z_low;
  logic signed [23:0] z_high;
  logic [15:0]        width;
  logic [15:0]        height;
} roi_regs_t;

class roi_scoreboard;
  roi_regs_t regs;
  region_t   expected_regions[$];
  int        mismatches;
  int        checked;
  int        status_seen[3];

  function new();
    regs.x_start = lpr_pkg::RST_VOL_X_START;
    regs.x_end   = lpr_pkg::RST_VOL_X_END;
    regs.y_start = lpr_pkg::RST_VOL_Y_START;
    regs.y_end   = lpr_pkg::RST_VOL_Y_END;
    regs.z_low   = lpr_pkg::RST_Z_LOW;
    regs.z_high  = lpr_pkg::RST_Z_HIGH;
    regs.width   = lpr_pkg::RST_PROJ_WIDTH;
    regs.height  = lpr_pkg::RST_PROJ_HEIGHT;
    mismatches   = 0;
    checked      = 0;
    foreach (status_seen[k]) status_seen[k] = 0;
  endfunction

  function void set_reg(lpr_pkg::reg_index_t idx, logic [23:0] data);
    case (idx)
      lpr_pkg::REG_VOL_X_START: regs.x_start = data[15:0];
      lpr_pkg::REG_VOL_X_END:   regs.x_end   = data[15:0];
      lpr_pkg::REG_VOL_Y_START: regs.y_start = data[15:0];
      lpr_pkg::REG_VOL_Y_END:   regs.y_end   = data[15:0];
      lpr_pkg::REG_Z_LOW:       regs.z_low   = data;
      lpr_pkg::REG_Z_HIGH:      regs.z_high  = data;
      lpr_pkg::REG_PROJ_WIDTH:  regs.width   = data[15:0];
      lpr_pkg::REG_PROJ_HEIGHT: regs.height  = data[15:0];
      default: ;
    endcase
  endfunction

  // Floor the low bound and ceil the high bound (both in Q<q>), clamp to
  // [0, size], then grow an empty range or flag an inverted one.
  function void clip_axis(input longint lo, input longint hi, input int q,
                          input longint size, output logic [15:0] first_idx,
                          output logic [15:0] end_idx, output lpr_pkg::status_t st);
    longint f, e;
    f  = lo >>> q;
    e  = -((-hi) >>> q);
    st = lpr_pkg::ST_OK;
    if (f < 0) f = 0;
    if (f > size) f = size;
    if (e < 0) e = 0;
    if (e > size) e = size;
    if (f == e) begin
      if (e < size) begin
        e = e + 1;
      end else if (f > 0) begin
        f = f - 1;
      end else begin
        st = lpr_pkg::ST_NO_EXTEND;
      end
    end else if (f > e) begin
      st = lpr_pkg::ST_INVERTED;
    end
    first_idx = f[15:0];
    end_idx   = e[15:0];
  endfunction

  function region_t project_region(angle_t a);
    longint  s, c, ls, lc, cx, cy, x0, x1, y0, y1, xs, xe, ys, ye, lo, hi, t;
    region_t r;
    s  = $signed(a.tomo_sine);
    c  = $signed(a.tomo_cosine);
    ls = $signed(a.lamino_sine);
    lc = $signed(a.lamino_cosine);
    cx = $signed(a.center_x);
    cy = $signed(a.center_y);
    x0 = regs.x_start;
    x1 = longint'(regs.x_end) - 1;
    y0 = regs.y_start;
    y1 = longint'(regs.y_end) - 1;

    // Columns in Q14: the corner pair is picked by the signs of sine and cosine.
    xs = x0; xe = x1; ys = y0; ye = y1;
    if (s < 0) begin t = ys; ys = ye; ye = t; end
    if (c < 0) begin t = xs; xs = xe; xe = t; end
    lo = c * xs + s * ys + cx * 64 - 64'sd16384;
    hi = c * xe + s * ye + cx * 64 + 64'sd16384;
    clip_axis(lo, hi, 14, regs.width, r.col_first, r.col_end, r.col_status);

    // Rows in Q28, with the x and y corners chosen the other way round.
    xs = x0; xe = x1; ys = y0; ye = y1;
    if (s < 0) begin t = xs; xs = xe; xe = t; end
    if (c > 0) begin t = ys; ys = ye; ye = t; end
    lo = (s * xs - c * ys) * lc + longint'(regs.z_low) * ls * 64
         + cy * 64'sd1048576 - 64'sd268435456;
    hi = (s * xe - c * ye) * lc + longint'(regs.z_high) * ls * 64
         + cy * 64'sd1048576 + 64'sd268435456;
    clip_axis(lo, hi, 28, regs.height, r.row_first, r.row_end, r.row_status);
    return r;
  endfunction

  function void note_angle(angle_t a);
    expected_regions.push_back(project_region(a));
  endfunction

  function void check_region(region_t got);
    region_t want;
    if (expected_regions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] output transaction with nothing expected: col %0d..%0d row %0d..%0d",
                 $time, got.col_first, got.col_end, got.row_first, got.row_end);
      return;
    end
    want = expected_regions.pop_front();
    checked++;
    status_seen[want.col_status]++;
    status_seen[want.row_status]++;
    if (got.col_first !== want.col_first || got.col_end !== want.col_end ||
        got.row_first !== want.row_first || got.row_end !== want.row_end ||
        got.col_status !== want.col_status || got.row_status !== want.row_status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] region mismatch: expected col %0d..%0d st %0d row %0d..%0d st %0d, got col %0d..%0d st %0d row %0d..%0d st %0d",
                 $time, want.col_first, want.col_end, want.col_status,
                 want.row_first, want.row_end, want.row_status,
                 got.col_first, got.col_end, got.col_status,
                 got.row_first, got.row_end, got.row_status);
    end
  endfunction
endclass

module lamino_projection_roi_unit_test;
  import lpr_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] tomo_sine;
  logic signed [15:0] tomo_cosine;
  logic signed [15:0] lamino_sine;
  logic signed [15:0] lamino_cosine;
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        col_first;
  logic [15:0]        col_end;
  logic [15:0]        row_first;
  logic [15:0]        row_end;
  status_t            col_status;
  status_t            row_status;

  roi_scoreboard sb;

  // Percent chance that a transaction (input side) or a cycle (output side)
  // starts an idle run. Set per phase so that some phases run flat out.
  int idle_pct = 30;
  int stall_pct = 30;
  int stall_run = 0;
  int settings_used = 0;

  lamino_projection_roi_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; a correct run ends far sooner even under the
  // longest stalls on both sides.
  initial begin
    #5_000_000;
    $display("lamino_projection_roi_unit regression: fail");
    $finish;
  end

  // Length of an idle run: none unless the percent draw hits, then mostly short, now and then long.
  function automatic int pick_run(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Output side. Outputs are sampled at the rising edge, where an output
  // transaction completes if out_valid is high and our out_stall is low.
  // The stall for the next cycle is chosen at the falling edge.
  initial begin
    region_t got;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.col_first  = col_first;
        got.col_end    = col_end;
        got.row_first  = row_first;
        got.row_end    = row_end;
        got.col_status = col_status;
        got.row_status = row_status;
        sb.check_region(got);
      end
      @(negedge clk);
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        stall_run = pick_run(stall_pct);
      end
    end
  end

  // Offer one input transaction. Entered and left just after a falling edge.
  // The gap is decided before the handshake, so valid never follows stall,
  // and the payload holds still while the block stalls it.
  task automatic send_item(angle_t a);
    int gap;
    gap = pick_run(idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    tomo_sine     <= a.tomo_sine;
    tomo_cosine   <= a.tomo_cosine;
    lamino_sine   <= a.lamino_sine;
    lamino_cosine <= a.lamino_cosine;
    center_x      <= a.center_x;
    center_y      <= a.center_y;
    do @(posedge clk); while (in_stall);
    sb.note_angle(a);
    @(negedge clk);
  endtask

  task automatic send_angle(int ts, int tc, int ls, int lc, int cx, int cy);
    angle_t a;
    a.tomo_sine     = 16'(ts);
    a.tomo_cosine   = 16'(tc);
    a.lamino_sine   = 16'(ls);
    a.lamino_cosine = 16'(lc);
    a.center_x      = 24'(cx);
    a.center_y      = 24'(cy);
    send_item(a);
  endtask

  // Hold the input idle until every expected region has come out, then wait
  // out the extra edges. It always waits for a falling edge first, so valid
  // is never lowered and raised in the same time step.
  task automatic drain(int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_regions.size() > 0);
    repeat (extra) @(negedge clk);
  endtask

  // The 16-bit registers get random junk in the unused upper byte of the
  // write data, which the block must ignore.
  task automatic write_reg(reg_index_t idx, logic [23:0] value);
    logic [23:0] data;
    data = value;
    if (idx != REG_Z_LOW && idx != REG_Z_HIGH) data[23:16] = 8'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Writes all eight registers once the pipeline (six stages) has emptied.
  task automatic apply_setting(int xs, int xe, int ys, int ye, int zl, int zh,
                               int w, int h);
    drain(8);
    write_reg(REG_VOL_X_START, 24'(xs));
    write_reg(REG_VOL_X_END,   24'(xe));
    write_reg(REG_VOL_Y_START, 24'(ys));
    write_reg(REG_VOL_Y_END,   24'(ye));
    write_reg(REG_Z_LOW,       24'(zl));
    write_reg(REG_Z_HIGH,      24'(zh));
    write_reg(REG_PROJ_WIDTH,  24'(w));
    write_reg(REG_PROJ_HEIGHT, 24'(h));
    settings_used++;
  endtask

  // Kinds: a plausible scan geometry, a tiny detector and volume that make
  // clamped and empty ranges common, raw random register bits, and a
  // geometry whose bounds are reversed so that ranges come out inverted.
  task automatic random_setting(int kind);
    int xs, ys, dx, dy, zl, zh, w, h;
    w  = $urandom_range(64, 4096);
    h  = $urandom_range(64, 4096);
    xs = int'($urandom_range(0, 600)) - 300;
    ys = int'($urandom_range(0, 600)) - 300;
    dx = $urandom_range(1, 512);
    dy = $urandom_range(1, 512);
    zl = -int'($urandom_range(0, 65536));
    zh = $urandom_range(0, 65536);
    case (kind)
      0: apply_setting(xs, xs + dx, ys, ys + dy, zl, zh, w, h);
      1: begin
        xs = int'($urandom_range(0, 4)) - 2;
        ys = int'($urandom_range(0, 4)) - 2;
        apply_setting(xs, xs + int'($urandom_range(0, 3)), ys,
                      ys + int'($urandom_range(0, 3)), zl / 64, zh / 64,
                      $urandom_range(1, 8), $urandom_range(1, 8));
      end
      2: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
      default: apply_setting(xs + dx, xs, ys + dy, ys, zh, zl, w, h);
    endcase
  endtask

  // Mostly well-formed angles: a sine and cosine pair on the unit circle and
  // a rotation center near the middle of the detector, scaled to its size.
  // One in eight transactions is raw random bits in every field.
  function automatic angle_t random_angle();
    angle_t a;
    int     s, c, span;
    if ($urandom_range(0, 7) == 0) begin
      a.tomo_sine     = 16'($urandom);
      a.tomo_cosine   = 16'($urandom);
      a.lamino_sine   = 16'($urandom);
      a.lamino_cosine = 16'($urandom);
      a.center_x      = 24'($urandom);
      a.center_y      = 24'($urandom);
      return a;
    end
    s = int'($urandom_range(0, 32768)) - 16384;
    c = $rtoi($sqrt(real'(268435456 - s * s)));
    if ($urandom_range(0, 1) == 1) c = -c;
    a.tomo_sine   = 16'(s);
    a.tomo_cosine = 16'(c);
    s = int'($urandom_range(0, 32768)) - 16384;
    c = $rtoi($sqrt(real'(268435456 - s * s)));
    if ($urandom_range(0, 1) == 1) c = -c;
    a.lamino_sine   = 16'(s);
    a.lamino_cosine = 16'(c);
    span = (int'(sb.regs.width) / 4 + 8) * 256;
    a.center_x = 24'(int'(sb.regs.width) * 128 + int'($urandom_range(0, 2 * span)) - span);
    span = (int'(sb.regs.height) / 4 + 8) * 256;
    a.center_y = 24'(int'(sb.regs.height) * 128 + int'($urandom_range(0, 2 * span)) - span);
    return a;
  endfunction

  initial begin
    sb = new();
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_VOL_X_START;
    cfg_data      = '0;
    in_valid      = 1'b0;
    tomo_sine     = '0;
    tomo_cosine   = '0;
    lamino_sine   = '0;
    lamino_cosine = '0;
    center_x      = '0;
    center_y      = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    settings_used = 1;

    // Register reset values: the four axis-aligned angles, a diagonal, the
    // largest legal values and the extreme 16-bit and 24-bit patterns.
    send_angle(0, 16384, 0, 16384, 262144, 262144);
    send_angle(16384, 0, 16384, 0, 262144, 262144);
    send_angle(0, -16384, 11585, 11585, 262144, 262144);
    send_angle(-16384, 0, -16384, 0, 262144, 262144);
    send_angle(11585, -11585, -11585, 11585, 0, 0);
    send_angle(16384, 16384, 16384, 16384, 8388607, 8388607);
    send_angle(-32768, -32768, -32768, -32768, -8388608, -8388608);
    send_angle(32767, 32767, 32767, 32767, 0, 0);

    // One-voxel volume on a 16-pixel detector. A center far below clamps
    // the range to zero and it grows upward; far above, it clamps to the
    // size and grows downward.
    apply_setting(0, 1, 0, 1, 0, 0, 16, 16);
    send_angle(0, 16384, 0, 16384, -8388608, -8388608);
    send_angle(0, 16384, 0, 16384, 8388607, 8388607);
    send_angle(0, 16384, 0, 16384, 2048, 2048);

    // Zero-size detector: the empty range cannot be extended.
    apply_setting(0, 1, 0, 1, 0, 0, 0, 0);
    send_angle(0, 16384, 0, 16384, 0, 0);
    send_angle(16384, 0, 16384, 0, 256, 256);

    // Reversed bounds, so the first index lands above the end.
    apply_setting(100, 0, 50, -20, 25600, -25600, 2048, 2048);
    send_angle(0, 16384, 16384, 0, 0, 0);
    send_angle(16384, 0, 0, 16384, 262144, 262144);
    send_angle(11585, 11585, 11585, 11585, 262144, 262144);

    // Extreme registers: widest volume, z extrema, largest detector.
    apply_setting(-32768, 32767, -32768, 32767, -8388608, 8388607, 65535, 65535);
    send_angle(16384, 16384, 16384, 16384, 0, 0);
    send_angle(-16384, -16384, -16384, -16384, 8388607, -8388608);
    send_angle(11585, -11585, 16384, 0, 0, 0);

    // Random phases. Phase 2 runs with no idling on either side, phase 5
    // with heavy idling. Halfway through each phase the sender waits for
    // the pipeline to empty completely before going on.
    for (int p = 0; p < 8; p++) begin
      idle_pct  = (p == 2) ? 0 : (p == 5) ? 60 : 30;
      stall_pct = idle_pct;
      random_setting(p % 4);
      for (int i = 0; i < 160; i++) begin
        if (i == 80) drain(0);
        send_item(random_angle());
      end
    end

    drain(12);
    $display("Checked %0d region transactions over %0d register settings.",
             sb.checked, settings_used);
    $display("Axis outcomes: %0d in range, %0d empty and stuck, %0d inverted; %0d mismatches.",
             sb.status_seen[ST_OK], sb.status_seen[ST_NO_EXTEND],
             sb.status_seen[ST_INVERTED], sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_regions.size() == 0) begin
      $display("lamino_projection_roi_unit regression: pass");
    end else begin
      $display("lamino_projection_roi_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== lamino_projection_roi_unit.f =====
sv/lpr_pkg.sv
sv/lamino_projection_roi_unit.sv
sim/lamino_projection_roi_unit_test.sv
